// ----- design/dtba_pkg.sv -----
// Package for the double-ended TLS block allocator.
// Holds sizing constants, status and register codes, payload structs and the
// alignment mask helper. No dependencies.
package dtba_pkg;

    localparam int PAD_BYTES  = 1048576;
    localparam int MAX_ALIGN  = 64;
    localparam int MAX_BLOCKS = 64;
    localparam int TCB_GAP    = 16;

    // Seat of the pad in the above-TP layout: TCB gap rounded up to MAX_ALIGN
    localparam int SEAT = ((TCB_GAP + MAX_ALIGN - 1) / MAX_ALIGN) * MAX_ALIGN;

    localparam int OP_W      = 1;
    localparam int SIZE_W    = 24;
    localparam int ALIGN_IN_W = 8;
    localparam int IMAGE_W   = 6;
    localparam int OFF_W     = 43;
    localparam int PAD_W     = 42;
    localparam int ST_W      = 3;
    localparam int EXT_W     = $clog2(PAD_BYTES) + 1;
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int ALIGN_W   = $clog2(MAX_ALIGN);
    localparam int SUM_W     = SIZE_W + 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_ALIGN_BIG   = 3'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED   = 3'd2;
    localparam logic [ST_W-1:0] ST_EXEC_PLACED = 3'd3;
    localparam logic [ST_W-1:0] ST_UNSEATED    = 3'd4;
    localparam logic [ST_W-1:0] ST_NO_ROOM     = 3'd5;

    localparam logic [OP_W-1:0] OP_LIBRARY    = 1'b0;
    localparam logic [OP_W-1:0] OP_EXECUTABLE = 1'b1;

    localparam logic LAYOUT_BELOW = 1'b0;
    localparam logic LAYOUT_ABOVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_OFFSET  = 1'b1;

    localparam logic [PAD_W-1:0] PAD_OFFSET_RESET = PAD_W'(0) - PAD_W'(PAD_BYTES);
    localparam logic [PAD_W-1:0] PAD_SEAT_ABOVE   = PAD_W'(SEAT);

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [SIZE_W-1:0]     block_size;
        logic [ALIGN_IN_W-1:0] block_align;
        logic [IMAGE_W-1:0]    image_low;
    } dtba_req_t;

    typedef struct packed {
        logic signed [OFF_W-1:0] block_offset;
        logic [ST_W-1:0]         status;
    } dtba_rsp_t;

    typedef struct packed {
        logic                    layout_mode;
        logic signed [PAD_W-1:0] pad_offset;
    } dtba_cfg_t;

    typedef struct packed {
        logic [EXT_W-1:0] library_extent;
        logic [EXT_W-1:0] executable_extent;
        logic             executable_placed;
        logic [CNT_W-1:0] blocks_reserved;
    } dtba_state_t;

    // Alignment minus one, with non-powers of two rounded up. Zero means 1.
    // Caller guarantees align <= MAX_ALIGN.
    function automatic logic [ALIGN_W-1:0] align_mask(input logic [ALIGN_IN_W-1:0] align);
        logic [ALIGN_IN_W-1:0] dec;
        logic [ALIGN_W-1:0]    m;
        dec = align - ALIGN_IN_W'(1);
        m   = (align == '0) ? '0 : dec[ALIGN_W-1:0];
        for (int i = ALIGN_W - 2; i >= 0; i--)
        begin
            m[i] = m[i] | m[i+1];
        end
        return m;
    endfunction

endpackage

// ----- design/dtba_cfg.sv -----
// Configuration registers of the block allocator: layout mode and pad offset.
// Depends on dtba_pkg.
module dtba_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dtba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dtba_pkg::PAD_W-1:0]     cfg_wdata,
    output dtba_pkg::dtba_cfg_t            cfg
);
    import dtba_pkg::*;

    logic             layout_mode_reg;
    logic [PAD_W-1:0] pad_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_mode_reg <= LAYOUT_BELOW;
            pad_offset_reg  <= PAD_OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LAYOUT_MODE: layout_mode_reg <= cfg_wdata[0];
                REG_PAD_OFFSET:  pad_offset_reg  <= cfg_wdata;
                default:         layout_mode_reg <= layout_mode_reg;
            endcase
        end
    end

    assign cfg.layout_mode = layout_mode_reg;
    assign cfg.pad_offset  = $signed(pad_offset_reg);

endmodule

// ----- design/dtba_core.sv -----
// Allocation datapath: checks one request against the current extents and
// produces the response and the next allocator state. Depends on dtba_pkg.
module dtba_core (
    input  dtba_pkg::dtba_req_t   req,
    input  dtba_pkg::dtba_cfg_t   cfg,
    input  dtba_pkg::dtba_state_t state,
    output dtba_pkg::dtba_rsp_t   rsp,
    output dtba_pkg::dtba_state_t state_next
);
    import dtba_pkg::*;

    logic [ALIGN_W-1:0] amask;
    logic [ALIGN_W-1:0] lmask;
    logic [SUM_W-1:0]   size_w;
    logic [SUM_W-1:0]   lib_w;
    logic [SUM_W-1:0]   exe_w;
    logic [SUM_W-1:0]   lmask_w;
    logic [SUM_W-1:0]   amask_w;
    logic [OFF_W-1:0]   pad_w;

    logic [SUM_W-1:0]   lib_start;
    logic [SUM_W-1:0]   lib_ext;
    logic [OFF_W-1:0]   lib_off;
    logic [SUM_W-1:0]   exe_ext;
    logic [SUM_W-1:0]   exe_span;
    logic [OFF_W-1:0]   exe_off;
    logic [SUM_W-1:0]   exe_pos;
    logic [SUM_W-1:0]   exe_end;
    logic               seated;
    logic               lib_room;
    logic               exe_room;

    always_comb
    begin
        amask   = align_mask(req.block_align);
        lmask   = amask | ALIGN_W'(7);
        size_w  = SUM_W'(req.block_size);
        lib_w   = SUM_W'(state.library_extent);
        exe_w   = SUM_W'(state.executable_extent);
        lmask_w = SUM_W'(lmask);
        amask_w = SUM_W'(amask);
        pad_w   = {{(OFF_W-PAD_W){cfg.pad_offset[PAD_W-1]}}, cfg.pad_offset};

        // Library blocks: packed from the far end of the pad
        lib_start = (lib_w + lmask_w) & ~lmask_w;
        if (cfg.layout_mode == LAYOUT_BELOW)
        begin
            lib_ext = lib_start + size_w;
            lib_off = pad_w + OFF_W'(lib_start);
        end
        else
        begin
            lib_ext = (lib_w + size_w + lmask_w) & ~lmask_w;
            lib_off = pad_w + OFF_W'(PAD_BYTES) - OFF_W'(lib_ext);
        end
        lib_room = (lib_ext + exe_w) <= SUM_W'(PAD_BYTES);

        // Executable block: at the thread-pointer end, congruent with the image
        exe_span = size_w + ((SUM_W'(0) - size_w - SUM_W'(req.image_low)) & amask_w);
        exe_pos  = SUM_W'(TCB_GAP)
                 + ((SUM_W'(req.image_low) - SUM_W'(TCB_GAP)) & amask_w);
        exe_end  = exe_pos + size_w;
        if (cfg.layout_mode == LAYOUT_BELOW)
        begin
            seated  = (cfg.pad_offset == PAD_OFFSET_RESET);
            exe_ext = exe_span;
            exe_off = OFF_W'(0) - OFF_W'(exe_span);
        end
        else
        begin
            seated  = (cfg.pad_offset == PAD_SEAT_ABOVE);
            exe_ext = (exe_end > SUM_W'(SEAT)) ? exe_end - SUM_W'(SEAT) : '0;
            exe_off = OFF_W'(exe_pos);
        end
        exe_room = (exe_ext + lib_w) <= SUM_W'(PAD_BYTES);

        rsp.block_offset = '0;
        rsp.status       = ST_OK;
        state_next       = state;

        priority if (req.block_align > ALIGN_IN_W'(MAX_ALIGN))
        begin
            rsp.status = ST_ALIGN_BIG;
        end
        else if (state.blocks_reserved >= CNT_W'(MAX_BLOCKS))
        begin
            rsp.status = ST_EXHAUSTED;
        end
        else if (req.op == OP_LIBRARY)
        begin
            if (!lib_room)
            begin
                rsp.status = ST_NO_ROOM;
            end
            else
            begin
                rsp.block_offset           = $signed(lib_off);
                state_next.library_extent  = lib_ext[EXT_W-1:0];
                state_next.blocks_reserved = state.blocks_reserved + CNT_W'(1);
            end
        end
        else if (state.executable_placed)
        begin
            rsp.status = ST_EXEC_PLACED;
        end
        else if (!seated)
        begin
            rsp.status = ST_UNSEATED;
        end
        else if (!exe_room)
        begin
            rsp.status = ST_NO_ROOM;
        end
        else
        begin
            rsp.block_offset             = $signed(exe_off);
            state_next.executable_extent = exe_ext[EXT_W-1:0];
            state_next.executable_placed = 1'b1;
            state_next.blocks_reserved   = state.blocks_reserved + CNT_W'(1);
        end
    end

endmodule

// ----- design/double_ended_tls_block_allocator.sv -----
// Double-ended TLS block allocator, top level: request register, allocator
// state and result register around dtba_core; config in dtba_cfg. Uses dtba_pkg.
// The result strobe follows start through the request register, then the result register.
// Throughput: one request per cycle; busy never rises, state updates on each request.
// Reset clears the extents, the block count and the placed flag, and sets the
// layout to below-TP with the pad ending at the thread pointer.
// Results cannot be stalled: each is shown for one cycle with done high.
module double_ended_tls_block_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  dtba_pkg::dtba_req_t             request,
    output logic                            done,
    output dtba_pkg::dtba_rsp_t             result,
    input  logic                            cfg_we,
    input  logic [dtba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dtba_pkg::PAD_W-1:0]      cfg_wdata
);
    import dtba_pkg::*;

    dtba_cfg_t   cfg;
    dtba_req_t   req_reg;
    logic        valid_reg;
    dtba_state_t state_reg;
    dtba_state_t state_next;
    dtba_rsp_t   rsp_next;
    dtba_rsp_t   rsp_reg;
    logic        done_reg;

    dtba_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dtba_core u_core (
        .req        (req_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .rsp        (rsp_next),
        .state_next (state_next)
    );

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
            if (valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        if (valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    // a strobe only follows an item held in the request register
    a_done_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg))
        else $error("result strobe without a request");

    a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> result.block_offset == '0)
        else $error("failed request returned a nonzero offset");

    a_count_tracks_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_OK)
            |-> state_reg.blocks_reserved == $past(state_reg.blocks_reserved) + CNT_W'(1))
        else $error("block count did not advance on success");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.blocks_reserved <= CNT_W'(MAX_BLOCKS))
        else $error("block count above limit");

    a_extents_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(state_reg.library_extent) + SUM_W'(state_reg.executable_extent))
            <= SUM_W'(PAD_BYTES))
        else $error("extents overlap");

endmodule
